[rtl/esort_pkg.sv]
`timescale 1ns / 1ps

package esort_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_I,
        ST_FETCH_I,
        ST_COMPARE,
        ST_WRITE_I,
        ST_EMIT
    } seq_state_t;

    typedef struct packed {
        logic load_wr;
        logic cur_ld;
        logic cmp_act;
        logic i_wr;
        logic rd_en;
    } ctl_t;

endpackage

[rtl/esort_cmp.sv]
`timescale 1ns / 1ps

module esort_cmp (
    input  logic signed [esort_pkg::DATA_W-1:0] a,
    input  logic signed [esort_pkg::DATA_W-1:0] b,
    input  logic                                descending,
    output logic                                swap
);
    import esort_pkg::*;

    logic a_gt_b;
    logic a_lt_b;

    assign a_gt_b = a > b;
    assign a_lt_b = a < b;

    // strict order test: equal entries swap
    always_comb
    begin
        if (descending)
        begin
            swap = !a_gt_b;
        end
        else
        begin
            swap = !a_lt_b;
        end
    end

endmodule

[rtl/esort_seq.sv]
`timescale 1ns / 1ps

module esort_seq #(
    parameter int MAX_ITEMS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          last_item,
    output logic                          busy,
    output esort_pkg::ctl_t               ctl,
    output logic [$clog2(MAX_ITEMS)-1:0]  load_addr,
    output logic [$clog2(MAX_ITEMS)-1:0]  i_addr,
    output logic [$clog2(MAX_ITEMS)-1:0]  j_addr,
    output logic [$clog2(MAX_ITEMS)-1:0]  rd_addr,
    output logic                          result_valid,
    output logic                          last_result,
    output logic                          dropped
);
    import esort_pkg::*;

    localparam int ADDR_W = $clog2(MAX_ITEMS);
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);

    seq_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic [ADDR_W-1:0]  i_reg, i_next;
    logic [ADDR_W-1:0]  j_reg, j_next;
    logic [ADDR_W-1:0]  k_reg, k_next;
    logic               emit_v_reg, emit_v_next;
    logic               emit_last_reg, emit_last_next;
    logic               emit_drop_reg, emit_drop_next;

    logic               accept;
    logic               full;
    logic [CNT_W-1:0]   last_idx;
    logic               i_at_end;
    logic               j_at_end;
    logic               k_at_end;

    assign accept    = start && (state_reg == ST_IDLE);
    assign full      = count_reg == CNT_W'(MAX_ITEMS);
    assign last_idx  = count_reg - CNT_W'(1);
    assign i_at_end  = CNT_W'(i_reg) == last_idx;
    assign j_at_end  = CNT_W'(j_reg) == last_idx;
    assign k_at_end  = CNT_W'(k_reg) == last_idx;

    assign busy      = state_reg != ST_IDLE;
    assign load_addr = count_reg[ADDR_W-1:0];
    assign i_addr    = i_reg;
    assign j_addr    = j_reg;

    assign result_valid = emit_v_reg;
    assign last_result  = emit_last_reg;
    assign dropped      = emit_drop_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && last_item)
                begin
                    state_next = ST_LOAD_I;
                end
            end
            ST_LOAD_I:
            begin
                state_next = ST_FETCH_I;
            end
            ST_FETCH_I:
            begin
                state_next = i_at_end ? ST_EMIT : ST_COMPARE;
            end
            ST_COMPARE:
            begin
                if (j_at_end)
                begin
                    state_next = ST_WRITE_I;
                end
            end
            ST_WRITE_I:
            begin
                state_next = ST_FETCH_I;
            end
            ST_EMIT:
            begin
                if (k_at_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl     = '0;
        rd_addr = i_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctl.load_wr = accept && !full;
            end
            ST_LOAD_I:
            begin
                ctl.rd_en = 1'b1;
            end
            ST_FETCH_I:
            begin
                ctl.cur_ld = 1'b1;
                ctl.rd_en  = !i_at_end;
                rd_addr    = i_reg + ADDR_W'(1);
            end
            ST_COMPARE:
            begin
                ctl.cmp_act = 1'b1;
                ctl.rd_en   = !j_at_end;
                rd_addr     = j_reg + ADDR_W'(1);
            end
            ST_WRITE_I:
            begin
                ctl.i_wr  = 1'b1;
                ctl.rd_en = 1'b1;
                rd_addr   = i_reg + ADDR_W'(1);
            end
            ST_EMIT:
            begin
                ctl.rd_en = 1'b1;
                rd_addr   = k_reg;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        emit_v_next    = 1'b0;
        emit_last_next = 1'b0;
        emit_drop_next = emit_drop_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                i_next = '0;
                k_next = '0;
                if (accept)
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            ST_LOAD_I:
            begin
            end
            ST_FETCH_I:
            begin
                j_next = i_reg + ADDR_W'(1);
            end
            ST_COMPARE:
            begin
                j_next = j_reg + ADDR_W'(1);
            end
            ST_WRITE_I:
            begin
                i_next = i_reg + ADDR_W'(1);
            end
            ST_EMIT:
            begin
                emit_v_next    = 1'b1;
                emit_last_next = k_at_end;
                emit_drop_next = ovf_reg;
                k_next         = k_reg + ADDR_W'(1);
                if (k_at_end)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            emit_v_reg    <= 1'b0;
            emit_last_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            emit_v_reg    <= emit_v_next;
            emit_last_reg <= emit_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg         <= i_next;
        j_reg         <= j_next;
        k_reg         <= k_next;
        emit_drop_reg <= emit_drop_next;
    end

`ifndef NO_ASSERTIONS
    a_strobe_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == ST_EMIT))
        else $error("result strobe without a read in emit state");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ITEMS))
        else $error("element count beyond capacity");

    a_j_after_i: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMPARE) |-> (j_reg > i_reg))
        else $error("compare index not past sort position");

    a_sort_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD_I) |-> (count_reg != '0))
        else $error("sort started on an empty set");
`endif

endmodule

[rtl/exchange_sort_engine.sv]
`timescale 1ns / 1ps

// channel   direction  handshake                    payload
// input     in         start && !busy               value, last_item
// config    in         cfg_valid && cfg_ready       cfg_data (descending)
// result    out        result_valid, one cycle      sorted_value, last_result, dropped
//
// Each accepted beat is written to the store while it has room. The beat marked
// last starts the sort, one compare per cycle while comparing, through the
// single comparator and the one-read, one-write element store. Results then
// stream one per cycle, one per held entry. busy is high from the last beat
// until the final read is issued. Reset is asynchronous, active low; the store
// is not cleared. The receiver cannot stall results.

module exchange_sort_engine #(
    parameter int MAX_ITEMS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [esort_pkg::DATA_W-1:0] value,
    input  logic                                last_item,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_data,
    output logic                                result_valid,
    output logic signed [esort_pkg::DATA_W-1:0] sorted_value,
    output logic                                last_result,
    output logic                                dropped
);
    import esort_pkg::*;

    localparam int ADDR_W = $clog2(MAX_ITEMS);

    ctl_t               ctl;
    logic [ADDR_W-1:0]  load_addr;
    logic [ADDR_W-1:0]  i_addr;
    logic [ADDR_W-1:0]  j_addr;
    logic [ADDR_W-1:0]  rd_addr;

    logic               desc_reg;
    logic [DATA_W-1:0]  store_mem [MAX_ITEMS];
    logic [DATA_W-1:0]  rd_data_reg;
    logic [DATA_W-1:0]  cur_reg, cur_next;

    logic               swap;
    logic               swap_wr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [DATA_W-1:0]  wr_data;

    esort_seq #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .last_item    (last_item),
        .busy         (busy),
        .ctl          (ctl),
        .load_addr    (load_addr),
        .i_addr       (i_addr),
        .j_addr       (j_addr),
        .rd_addr      (rd_addr),
        .result_valid (result_valid),
        .last_result  (last_result),
        .dropped      (dropped)
    );

    esort_cmp u_cmp (
        .a          (cur_reg),
        .b          (rd_data_reg),
        .descending (desc_reg),
        .swap       (swap)
    );

    assign cfg_ready    = 1'b1;
    assign sorted_value = rd_data_reg;

    assign swap_wr = ctl.cmp_act && swap;
    assign wr_en   = ctl.load_wr || ctl.i_wr || swap_wr;

    always_comb
    begin
        priority if (ctl.load_wr)
        begin
            wr_addr = load_addr;
            wr_data = value;
        end
        else if (ctl.i_wr)
        begin
            wr_addr = i_addr;
            wr_data = cur_reg;
        end
        else
        begin
            wr_addr = j_addr;
            wr_data = cur_reg;
        end
    end

    // entry i lives in cur_reg while its later entries stream past
    always_comb
    begin
        cur_next = cur_reg;
        if (ctl.cur_ld || swap_wr)
        begin
            cur_next = rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            desc_reg <= cfg_data;
        end
    end

endmodule
